// File: hw/rtl/phhm_pkg.sv
// shared constants, codes and types of the pointer handle hash map
package phhm_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam bit          TABLE_POW2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  // handle layout: three tag bits over a 29-bit key
  localparam int unsigned KEY_W      = 29;
  localparam int unsigned PTR_W      = 64;
  localparam int unsigned HANDLE_W   = 32;
  localparam logic [2:0]  KEY_TAG    = 3'b111;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}};

  // candidate keys tried per encode
  localparam int unsigned KEY_TRIES  = 65536;
  localparam int unsigned TRIES_W    = $clog2(KEY_TRIES);

  // home slot of the first tagged key, taken after the key wraps
  localparam logic [SLOT_W-1:0] TAG_SLOT = SLOT_W'(32'hE000_0000 % TABLE_ENTRIES);

  // table entry: pointer above key
  localparam int unsigned ENTRY_W = PTR_W + KEY_W;

  // reciprocal of the table size for the home slot when the size is not a power of two
  localparam int unsigned RECIP_W     = HANDLE_W + 1;
  localparam int unsigned RECIP_SHIFT = HANDLE_W + SLOT_W;
  localparam int unsigned QUOT_W      = HANDLE_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISS      = 3'd1,
    ST_BAD_TAG   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  // request to the slot reduction unit
  typedef struct packed {
    logic                start;
    logic [HANDLE_W-1:0] value;
  } mod_req_t;

  // answer of the slot reduction unit
  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } mod_rsp_t;

endpackage

// File: hw/rtl/phhm_ram.sv
// generic single write port ram with registered read
module phhm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/phhm_mod.sv
// key to home slot reduction: low bits for a power of two table size, reciprocal multiplication otherwise
module phhm_mod (
  input  logic               clk,
  input  logic               rst,
  input  phhm_pkg::mod_req_t req,
  output phhm_pkg::mod_rsp_t rsp
);

  localparam logic [phhm_pkg::SLOT_W:0] SIZE =
    (phhm_pkg::SLOT_W + 1)'(phhm_pkg::TABLE_ENTRIES);
  localparam int unsigned PROD_W = phhm_pkg::HANDLE_W + phhm_pkg::RECIP_W;
  localparam int unsigned BACK_W = phhm_pkg::QUOT_W + phhm_pkg::SLOT_W + 1;

  logic [phhm_pkg::HANDLE_W-1:0] val;
  logic [phhm_pkg::QUOT_W-1:0]   quot;
  logic [phhm_pkg::SLOT_W:0]     diff;
  logic [phhm_pkg::SLOT_W:0]     wrapped;
  logic [phhm_pkg::SLOT_W-1:0]   direct;
  logic [PROD_W-1:0]             prod;
  logic [BACK_W-1:0]             back;
  logic                          stage1;
  logic                          stage2;
  logic                          done;

  // quotient estimate, low by at most one
  assign prod = {{phhm_pkg::RECIP_W{1'b0}}, val} * {{phhm_pkg::HANDLE_W{1'b0}}, phhm_pkg::RECIP};
  // quotient times size, only the low bits matter
  assign back = {{(phhm_pkg::SLOT_W + 1){1'b0}}, quot} * {{phhm_pkg::QUOT_W{1'b0}}, SIZE};
  // remainder stays below twice the size: one compare and subtract
  assign wrapped = (diff >= SIZE) ? diff - SIZE : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= req.start && !phhm_pkg::TABLE_POW2;
      stage2 <= stage1;
      // power of two size: low bits are the slot, ready at once
      done   <= (req.start && phhm_pkg::TABLE_POW2) || stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val    <= req.value;
      direct <= req.value[phhm_pkg::SLOT_W-1:0];
    end
    if (stage1) begin
      quot <= prod[PROD_W-1:phhm_pkg::RECIP_SHIFT];
    end
    if (stage2) begin
      diff <= val[phhm_pkg::SLOT_W:0] - back[phhm_pkg::SLOT_W:0];
    end
  end

  assign rsp.done = done;
  assign rsp.slot = phhm_pkg::TABLE_POW2 ? direct : wrapped[phhm_pkg::SLOT_W-1:0];

endmodule

// File: hw/rtl/pointer_handle_hash_map_core.sv
// top level of the pointer handle hash map: probe sequencer, table and result register
//
//   channel  dir  words                  handshake
//   s_axis   in   one request per word   s_axis_tvalid / s_axis_tready
//   m_axis   out  one result per request m_axis_tvalid / m_axis_tready
//
// after reset a clearing pass writes every table slot to empty,
// while s_axis_tready stays low
// a request passes an accept state, the home slot reduction (the low bits for a power
// of two table, reciprocal multiplication otherwise), a read and a check state per
// table probe through the registered ram read port, and a handover state; the probe
// chain length depends on the data; one request is in work at a time; the finished
// result waits in the output register, and the next request is taken while it waits
// a stalled m_axis holds the sequencer in its handover state
module pointer_handle_hash_map_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // pointer_in[63:0], handle_in[95:64]
  input  logic        s_axis_tuser,   // command (0 encode, 1 decode)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // handle_out[31:0], pointer_out[95:32]
  output logic [3:0]  m_axis_tuser    // new_entry[0], status[3:1]
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  localparam logic [phhm_pkg::SLOT_W-1:0]  LAST_SLOT =
    phhm_pkg::SLOT_W'(phhm_pkg::TABLE_ENTRIES - 1);
  localparam logic [phhm_pkg::TRIES_W-1:0] LAST_TRY  =
    phhm_pkg::TRIES_W'(phhm_pkg::KEY_TRIES - 1);

  // pointer fold: three xor-shifts, low 29 bits kept
  function automatic logic [phhm_pkg::KEY_W-1:0] fold_ptr(input logic [63:0] p);
    logic [63:0] x;
    x = p ^ (p >> 33);
    x = x ^ (x >> 17);
    x = x ^ (x >> 9);
    return x[phhm_pkg::KEY_W-1:0];
  endfunction

  state_t state;

  // request context
  logic                          is_dec;
  logic [phhm_pkg::PTR_W-1:0]    req_ptr;
  logic [phhm_pkg::KEY_W-1:0]    key_low;
  logic [phhm_pkg::TRIES_W-1:0]  tries;

  // probe walk; slot doubles as the clear address
  logic [phhm_pkg::SLOT_W-1:0]   slot;
  logic [phhm_pkg::SLOT_W-1:0]   cand_slot;
  logic [phhm_pkg::SLOT_W-1:0]   probe_cnt;
  logic [phhm_pkg::SLOT_W-1:0]   slot_inc;
  logic [phhm_pkg::SLOT_W-1:0]   cand_next;

  // result being built
  logic [phhm_pkg::HANDLE_W-1:0] res_handle;
  logic [phhm_pkg::PTR_W-1:0]    res_ptr;
  logic                          res_new;
  phhm_pkg::status_t             res_status;

  // output register
  logic [phhm_pkg::HANDLE_W-1:0] out_handle;
  logic [phhm_pkg::PTR_W-1:0]    out_ptr;
  logic                          out_new;
  phhm_pkg::status_t             out_status;
  logic                          out_valid;

  // input word fields
  logic                          in_cmd;
  logic [phhm_pkg::PTR_W-1:0]    in_ptr;
  logic [phhm_pkg::HANDLE_W-1:0] in_handle;
  logic [phhm_pkg::KEY_W-1:0]    in_fold;
  logic                          accept;

  // table port
  logic                          ram_we;
  logic [phhm_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [phhm_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [phhm_pkg::KEY_W-1:0]    rd_key;
  logic [phhm_pkg::PTR_W-1:0]    rd_ptr;

  phhm_pkg::mod_req_t            mod_req;
  phhm_pkg::mod_rsp_t            mod_rsp;

  assign in_cmd    = s_axis_tuser;
  assign in_ptr    = s_axis_tdata[63:0];
  assign in_handle = s_axis_tdata[95:64];
  assign in_fold   = fold_ptr(in_ptr);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // home slot of the first key; null pointers and bad tags skip the reduction
  always_comb begin
    mod_req.value = in_cmd ? in_handle : {phhm_pkg::KEY_TAG, in_fold};
    mod_req.start = accept && (in_cmd ? (in_handle[31:29] == phhm_pkg::KEY_TAG)
                                      : (in_ptr != '0));
  end

  phhm_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign rd_key = ram_rdata[phhm_pkg::KEY_W-1:0];
  assign rd_ptr = ram_rdata[phhm_pkg::KEY_W +: phhm_pkg::PTR_W];

  // slot walk with wrap, and the home slot of the next candidate key
  assign slot_inc  = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign cand_next = (key_low == phhm_pkg::KEY_MASK) ? phhm_pkg::TAG_SLOT
                   : ((cand_slot == LAST_SLOT) ? '0 : cand_slot + 1'b1);

  // clear pass writes empty slots, an encode claims the empty slot it found
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_CHECK && !is_dec && rd_ptr == '0) begin
      ram_we    = 1'b1;
      ram_wdata = {req_ptr, key_low};
    end
  end

  phhm_ram #(
    .WIDTH (phhm_pkg::ENTRY_W),
    .DEPTH (phhm_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // probe sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      slot  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          slot <= slot_inc;
          if (slot == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            is_dec     <= in_cmd;
            req_ptr    <= in_ptr;
            key_low    <= in_cmd ? in_handle[phhm_pkg::KEY_W-1:0] : in_fold;
            tries      <= '0;
            res_handle <= '0;
            res_ptr    <= '0;
            res_new    <= 1'b0;
            // a handle without the tag is answered at once
            res_status <= (in_cmd && !mod_req.start) ? phhm_pkg::ST_BAD_TAG : phhm_pkg::ST_OK;
            if (mod_req.start) begin
              state <= S_MOD;
            end else begin
              // null pointer, or a handle without the tag
              state <= S_RESP;
            end
          end
        end

        S_MOD: begin
          if (mod_rsp.done) begin
            slot      <= mod_rsp.slot;
            cand_slot <= mod_rsp.slot;
            probe_cnt <= '0;
            state     <= S_READ;
          end
        end

        S_READ: begin
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (rd_ptr == '0) begin
            // empty slot ends the chain
            if (is_dec) begin
              res_status <= phhm_pkg::ST_MISS;
            end else begin
              res_handle <= {phhm_pkg::KEY_TAG, key_low};
              res_new    <= 1'b1;
            end
            state <= S_RESP;
          end else if (rd_key == key_low) begin
            if (is_dec) begin
              res_ptr <= rd_ptr;
              state   <= S_RESP;
            end else if (rd_ptr == req_ptr) begin
              res_handle <= {phhm_pkg::KEY_TAG, key_low};
              state      <= S_RESP;
            end else if (tries == LAST_TRY) begin
              res_status <= phhm_pkg::ST_EXHAUSTED;
              state      <= S_RESP;
            end else begin
              // key taken by another pointer: next candidate key
              tries     <= tries + 1'b1;
              key_low   <= key_low + 1'b1;
              cand_slot <= cand_next;
              slot      <= cand_next;
              probe_cnt <= '0;
              state     <= S_READ;
            end
          end else if (probe_cnt == LAST_SLOT) begin
            // whole table walked without a hit or an empty slot
            res_status <= is_dec ? phhm_pkg::ST_MISS : phhm_pkg::ST_FULL;
            state      <= S_RESP;
          end else begin
            slot      <= slot_inc;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= S_READ;
          end
        end

        S_RESP: begin
          if (!out_valid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!out_valid || m_axis_tready)) begin
      out_handle <= res_handle;
      out_ptr    <= res_ptr;
      out_new    <= res_new;
      out_status <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_ptr, out_handle};
  assign m_axis_tuser  = {out_status, out_new};

  // a fresh entry is only reported with an ok encode
  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_new |-> out_status == phhm_pkg::ST_OK && out_handle != '0)
    else $error("new entry flagged on a failed result");

  // a result never carries both a handle and a pointer
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_handle != '0 |-> out_ptr == '0)
    else $error("handle and pointer both set");

  // the reduction unit answers only while the sequencer waits for it
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == S_MOD)
    else $error("slot reduction done outside its wait state");

  // table writes only during the clear pass or a probe check
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_CLEAR || state == S_CHECK)
    else $error("table write in wrong state");

  // the sequencer leaves the handover state only when the output register takes the result
  a_resp_load: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("result lost at handover");

endmodule
